>>> rtl/core/atsp_pkg.sv
// Shared types, character codes and helpers for the tagged-field search core.
// Used by atsp_parser and aux_tag_search_parser_core; depends on nothing.
package atsp_pkg;

    // Default record length bound for offset saturation.
    localparam int MaxRecordBytesDefault = 65536;

    localparam int TagW     = 16;
    localparam int ByteW    = 8;
    localparam int OffsetW  = 16;
    localparam int PayloadW = 35;
    localparam int CountW   = 24;  // low three count bytes; the fourth arrives live

    // Type characters of the field format.
    localparam logic [ByteW-1:0] ChrZ     = 8'h5A;  // 'Z'
    localparam logic [ByteW-1:0] ChrB     = 8'h42;  // 'B'
    localparam logic [ByteW-1:0] ChrUpC   = 8'h43;  // 'C'
    localparam logic [ByteW-1:0] ChrLoC   = 8'h63;  // 'c'
    localparam logic [ByteW-1:0] ChrA     = 8'h41;  // 'A'
    localparam logic [ByteW-1:0] ChrUpS   = 8'h53;  // 'S'
    localparam logic [ByteW-1:0] ChrLoS   = 8'h73;  // 's'
    localparam logic [ByteW-1:0] ChrUpI   = 8'h49;  // 'I'
    localparam logic [ByteW-1:0] ChrLoI   = 8'h69;  // 'i'
    localparam logic [ByteW-1:0] ChrF     = 8'h66;  // 'f'
    localparam logic [ByteW-1:0] ChrNul   = 8'h00;

    localparam logic [1:0] CntLastIdx = 2'd3;

    // Parse phase of the current field.
    typedef enum logic [2:0] {
        PH_TAG0 = 3'd0,
        PH_TAG1 = 3'd1,
        PH_TYPE = 3'd2,
        PH_SKIP = 3'd3,
        PH_ZSTR = 3'd4,
        PH_BSUB = 3'd5,
        PH_BCNT = 3'd6,
        PH_DONE = 3'd7
    } t_phase;

    // One result item as produced by the parser for the current byte.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [OffsetW-1:0] value_offset;
    } t_result;

    // Payload size in bytes of a scalar type; zero for anything else.
    function automatic logic [2:0] elem_size(input logic [ByteW-1:0] t);
        logic [2:0] sz;
        sz = 3'd0;
        if (t == ChrUpC || t == ChrLoC || t == ChrA) begin
            sz = 3'd1;
        end else if (t == ChrUpS || t == ChrLoS) begin
            sz = 3'd2;
        end else if (t == ChrUpI || t == ChrLoI || t == ChrF) begin
            sz = 3'd4;
        end
        return sz;
    endfunction

endpackage

>>> rtl/core/atsp_parser.sv
// Per-byte field parser: phase machine, skip counter and byte position.
// Depends on atsp_pkg; instantiated by aux_tag_search_parser_core.
module atsp_parser #(
    parameter int MAX_RECORD_BYTES = atsp_pkg::MaxRecordBytesDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [atsp_pkg::TagW-1:0]     i_search_tag,
    input  logic                          i_step,
    input  logic [atsp_pkg::ByteW-1:0]    i_byte,
    input  logic                          i_last,
    output atsp_pkg::t_result             o_result
);

    localparam int Limit = (MAX_RECORD_BYTES - 1 > 65535) ? 65535 : MAX_RECORD_BYTES - 1;
    localparam int PosW  = $clog2(Limit + 1);
    localparam logic [PosW-1:0] PosLimit = PosW'(Limit);

    atsp_pkg::t_phase                  r_phase, n_phase;
    logic [atsp_pkg::ByteW-1:0]        r_held, n_held;
    logic [atsp_pkg::PayloadW-1:0]     r_left, n_left;
    logic [2:0]                        r_esize, n_esize;
    logic [atsp_pkg::CountW-1:0]       r_count, n_count;
    logic [1:0]                        r_cidx, n_cidx;
    logic [PosW-1:0]                   r_pos, n_pos;

    logic [PosW-1:0]                   pos_next;
    logic                              tag_hit;
    logic [2:0]                        byte_size;
    logic [31:0]                       full_count;
    logic [atsp_pkg::PayloadW-1:0]     array_bytes;
    logic [atsp_pkg::PayloadW-1:0]     left_dec;

    // Shared decode of the current byte.
    assign pos_next   = (r_pos >= PosLimit) ? PosLimit : r_pos + PosW'(1);
    assign tag_hit    = ({r_held, i_byte} == i_search_tag);
    assign byte_size  = atsp_pkg::elem_size(i_byte);
    assign full_count = {i_byte, r_count};
    assign left_dec   = r_left - atsp_pkg::PayloadW'(1);

    // Array length in bytes: element sizes are powers of two, so a shift.
    always_comb begin
        unique case (r_esize)
            3'd1:    array_bytes = {3'b000, full_count};
            3'd2:    array_bytes = {2'b00, full_count, 1'b0};
            3'd4:    array_bytes = {1'b0, full_count, 2'b00};
            default: array_bytes = '0;
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            atsp_pkg::PH_TAG0: n_phase = atsp_pkg::PH_TAG1;
            atsp_pkg::PH_TAG1: n_phase = tag_hit ? atsp_pkg::PH_DONE : atsp_pkg::PH_TYPE;
            atsp_pkg::PH_TYPE: begin
                if (i_byte == atsp_pkg::ChrZ) begin
                    n_phase = atsp_pkg::PH_ZSTR;
                end else if (i_byte == atsp_pkg::ChrB) begin
                    n_phase = atsp_pkg::PH_BSUB;
                end else begin
                    n_phase = (byte_size != 3'd0) ? atsp_pkg::PH_SKIP : atsp_pkg::PH_TAG0;
                end
            end
            atsp_pkg::PH_SKIP: n_phase = (left_dec == '0) ? atsp_pkg::PH_TAG0 : atsp_pkg::PH_SKIP;
            atsp_pkg::PH_ZSTR: begin
                n_phase = (i_byte == atsp_pkg::ChrNul) ? atsp_pkg::PH_TAG0 : atsp_pkg::PH_ZSTR;
            end
            atsp_pkg::PH_BSUB: n_phase = atsp_pkg::PH_BCNT;
            atsp_pkg::PH_BCNT: begin
                if (r_cidx == atsp_pkg::CntLastIdx) begin
                    n_phase = (array_bytes != '0) ? atsp_pkg::PH_SKIP : atsp_pkg::PH_TAG0;
                end
            end
            atsp_pkg::PH_DONE: n_phase = atsp_pkg::PH_DONE;
            default:           n_phase = atsp_pkg::PH_TAG0;
        endcase
        if (i_last) begin
            n_phase = atsp_pkg::PH_TAG0;
        end
    end

    // Datapath updates and the result for the current byte.
    always_comb begin
        n_held   = r_held;
        n_left   = r_left;
        n_esize  = r_esize;
        n_count  = r_count;
        n_cidx   = r_cidx;
        n_pos    = pos_next;
        o_result = '0;

        unique case (r_phase)
            atsp_pkg::PH_TAG0: n_held = i_byte;
            atsp_pkg::PH_TAG1: begin
                if (tag_hit) begin
                    o_result.valid        = 1'b1;
                    o_result.found        = 1'b1;
                    o_result.value_offset = atsp_pkg::OffsetW'(pos_next);
                end
            end
            atsp_pkg::PH_TYPE: n_left = atsp_pkg::PayloadW'(byte_size);
            atsp_pkg::PH_SKIP: n_left = left_dec;
            atsp_pkg::PH_BSUB: begin
                n_esize = byte_size;
                n_count = '0;
                n_cidx  = 2'd0;
            end
            atsp_pkg::PH_BCNT: begin
                unique case (r_cidx)
                    2'd0:    n_count[7:0]   = i_byte;
                    2'd1:    n_count[15:8]  = i_byte;
                    2'd2:    n_count[23:16] = i_byte;
                    default: n_left         = array_bytes;
                endcase
                n_cidx = r_cidx + 2'd1;
            end
            default: ;
        endcase

        // End of record: report a miss unless a hit was already given.
        if (i_last) begin
            if (r_phase != atsp_pkg::PH_DONE && !(r_phase == atsp_pkg::PH_TAG1 && tag_hit)) begin
                o_result.valid        = 1'b1;
                o_result.found        = 1'b0;
                o_result.value_offset = '0;
            end
            n_held  = '0;
            n_left  = '0;
            n_esize = '0;
            n_count = '0;
            n_cidx  = '0;
            n_pos   = '0;
        end
    end

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= atsp_pkg::PH_TAG0;
            r_held  <= '0;
            r_left  <= '0;
            r_esize <= '0;
            r_count <= '0;
            r_cidx  <= '0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_left  <= n_left;
            r_esize <= n_esize;
            r_count <= n_count;
            r_cidx  <= n_cidx;
            r_pos   <= n_pos;
        end
    end

endmodule

>>> rtl/core/aux_tag_search_parser_core.sv
// Top level of the tagged-field search core: stream ports, input and result registers.
// Depends on atsp_pkg and atsp_parser.
//
// The core takes one record byte per item and finds the first field whose two
// tag bytes equal the configured search tag. Each record gives exactly one
// result item: on a hit, tuser is 1 and tdata is the offset of the field's type
// byte (saturating at MAX_RECORD_BYTES-1 or 65535); a record that ends without
// a hit gives tuser 0 and offset 0. A hit is reported on the second tag byte and
// the rest of the record is then skipped. Items flow at one per clock: a byte
// is registered on entry, parsed by the phase machine and skip counter once the
// output register can take its result, and its result is written to the output
// register in that same step. Input stalls only while the output register holds
// a result that is not taken. The search tag is written through the configuration
// channel; the user must write it only while no record is in flight, as the block
// itself does not enforce this.
module aux_tag_search_parser_core #(
    parameter int MAX_RECORD_BYTES = atsp_pkg::MaxRecordBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration: search tag, first character in the upper byte.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // [15:0] search_tag

    // Record bytes in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // record_end

    // Search results out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] value_offset
    output logic [0:0]  m_axis_tuser    // [0] found
);

    logic [atsp_pkg::TagW-1:0]  r_search_tag;
    logic                       r_in_valid;
    logic [atsp_pkg::ByteW-1:0] r_in_byte;
    logic                       r_in_last;
    logic                       r_out_valid;
    logic                       r_out_found;
    logic [atsp_pkg::OffsetW-1:0] r_out_offset;

    logic                       step;
    atsp_pkg::t_result          result;

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_tag <= '0;
        end else if (i_cfg_valid) begin
            r_search_tag <= i_cfg_data;
        end
    end

    // A registered item is parsed when the result register can take its result.
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    atsp_parser #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_search_tag (r_search_tag),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .o_result     (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= result.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.valid) begin
            r_out_found  <= result.found;
            r_out_offset <= result.value_offset;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_offset;
    assign m_axis_tuser[0] = r_out_found;

endmodule
